### sv/ac3hp_pkg.sv
`default_nettype none
package ac3hp_pkg;

  // Frame buffer: two banks of 64 bytes, the bank is the top address bit.
  localparam int BankBytes = 64;
  localparam int RamDepth  = 2 * BankBytes;
  localparam int RamAw     = $clog2(RamDepth);
  localparam int IdxW      = $clog2(BankBytes);

  localparam logic [7:0] SYNC_HI      = 8'h0B;
  localparam logic [7:0] SYNC_LO      = 8'h77;
  localparam logic [4:0] BSID_AC3_MAX = 5'd10;
  localparam logic [6:0] CNT_MAX      = 7'd127;
  localparam logic [6:0] MIN_LEN      = 7'd7;
  localparam logic [1:0] FSCOD_EXT    = 2'd3;
  localparam logic [2:0] ACMOD_DUAL   = 3'd0;
  localparam logic [2:0] ACMOD_STEREO = 3'd2;
  localparam logic [1:0] DSUR_ON      = 2'd2;
  localparam logic [2:0] BSMOD_VO     = 3'd7;

  typedef struct packed {
    logic             bank;
    logic [6:0]       count;
    logic [6:0][7:0]  hdr;
  } ac3hp_desc_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } ac3hp_qstat_t;

  function automatic logic [15:0] rate_hz(input logic [1:0] fscod, input logic [1:0] fscod2);
    logic [15:0] r;
    case (fscod)
      2'd0: r = 16'd48000;
      2'd1: r = 16'd44100;
      2'd2: r = 16'd32000;
      default: begin
        case (fscod2)
          2'd0: r = 16'd24000;
          2'd1: r = 16'd22050;
          2'd2: r = 16'd16000;
          default: r = 16'd0;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] comp_type(input logic eac3, input logic [2:0] bsmod,
                                           input logic [2:0] acmod, input logic sur);
    logic [7:0] c;
    c = eac3 ? 8'h80 : 8'h00;
    if (bsmod < 3'd2 || (bsmod == BSMOD_VO && acmod > 3'd1)) c = c | 8'h40;
    c = c | {2'b00, bsmod, 3'b000};
    if (acmod == ACMOD_DUAL) c = c | 8'h01;
    else if (acmod == ACMOD_STEREO) c = c | (sur ? 8'h03 : 8'h02);
    else if (acmod > ACMOD_STEREO) c = c | 8'h04;
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/ac3hp_if.sv
`default_nettype none
interface ac3hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       first_byte;
  logic       last_byte;
  modport source(output valid, frame_byte, first_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, first_byte, last_byte, output ready);
endinterface

interface ac3hp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        changed;
  logic        is_eac3;
  logic [4:0]  bitstream_id;
  logic [2:0]  service_mode;
  logic [2:0]  coding_mode;
  logic        dolby_surround;
  logic [15:0] sample_rate_hz;
  logic [7:0]  dvb_audio_type;
  logic        attributes_valid;
  modport source(output valid, accepted, changed, is_eac3, bitstream_id, service_mode,
                 coding_mode, dolby_surround, sample_rate_hz, dvb_audio_type,
                 attributes_valid, input ready);
  modport sink(input valid, accepted, changed, is_eac3, bitstream_id, service_mode,
               coding_mode, dolby_surround, sample_rate_hz, dvb_audio_type,
               attributes_valid, output ready);
endinterface
`default_nettype wire

### sv/ac3_eac3_header_attribute_parser.sv
`default_nettype none
// An AC-3 or rejected frame is written into the queue on its last byte beat; its result beat
// is then loaded from the queue head into the result register once the output slot is free.
// An E-AC-3 frame first walks its bitstream-information fields before its result is loaded.
// Throughput: one byte beat per cycle while ready is high.
// Input stalls only when two finished frames wait in the queue, both buffer banks in use.
// Reset (rst, synchronous, active high) clears stored attributes, counters and the queue.
module ac3_eac3_header_attribute_parser (
  input  logic        clk,
  input  logic        rst,
  ac3hp_in_if.sink    in_ch,
  ac3hp_out_if.source out_ch
);
  import ac3hp_pkg::*;

  // The front end counts byte beats, keeps the first seven header bytes in
  // flip-flops, and writes up to 64 bytes of each frame into one bank of the
  // frame buffer. On the last beat it queues a frame descriptor and flips to
  // the other bank. The back end decodes the header of the queue head and, for
  // E-AC-3, walks the bitstream information fields out of the buffer (address,
  // then registered read data for each field) to find bsmod. It then
  // compares with the stored attributes, commits, and loads the result
  // register, which frees the queue entry and its bank.

  ac3hp_qstat_t          qstat;
  ac3hp_desc_t           push_desc;
  ac3hp_desc_t           head;
  logic                  push;
  logic                  pop;
  logic                  wr_en;
  logic [RamAw-1:0]      wr_addr;
  logic [7:0]            wr_data;
  logic [RamAw-1:0]      rd_addr_a;
  logic [RamAw-1:0]      rd_addr_b;
  logic [7:0]            rd_data_a;
  logic [7:0]            rd_data_b;

  ac3hp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .qstat     (qstat),
    .push      (push),
    .push_desc (push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ac3hp_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  ac3hp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ac3hp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

### sv/ac3hp_ram.sv
`default_nettype none
module ac3hp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule
`default_nettype wire

### sv/ac3hp_front.sv
`default_nettype none
module ac3hp_front (
  input  logic                      clk,
  input  logic                      rst,
  ac3hp_in_if.sink                  in_ch,
  input  ac3hp_pkg::ac3hp_qstat_t   qstat,
  output logic                      push,
  output ac3hp_pkg::ac3hp_desc_t    push_desc,
  output logic                      wr_en,
  output logic [ac3hp_pkg::RamAw-1:0] wr_addr,
  output logic [7:0]                wr_data
);
  import ac3hp_pkg::*;

  logic [6:0]      cnt;
  logic            wb;
  logic [6:0][7:0] hdr;
  logic [6:0][7:0] hdr_cur;
  logic [6:0]      idx;
  logic [6:0]      cnt_inc;
  logic            beat;

  // Both banks are held by queued frames when the queue is full.
  assign in_ch.ready = !qstat.full;
  assign beat = in_ch.valid && in_ch.ready;
  assign idx = in_ch.first_byte ? 7'd0 : cnt;
  assign cnt_inc = (idx == CNT_MAX) ? CNT_MAX : idx + 7'd1;

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      hdr_cur[k] = (beat && idx == 7'(k)) ? in_ch.frame_byte : hdr[k];
    end
  end

  assign wr_en   = beat && (idx < 7'(BankBytes));
  assign wr_addr = {wb, idx[IdxW-1:0]};
  assign wr_data = in_ch.frame_byte;

  assign push = beat && in_ch.last_byte;
  assign push_desc = '{bank: wb, count: cnt_inc, hdr: hdr_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wb  <= 1'b0;
    end else if (beat) begin
      if (in_ch.last_byte) begin
        cnt <= '0;
        wb  <= !wb;
      end else begin
        cnt <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) hdr <= hdr_cur;
  end
endmodule
`default_nettype wire

### sv/ac3hp_queue.sv
`default_nettype none
module ac3hp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ac3hp_pkg::ac3hp_desc_t  push_desc,
  input  logic                    pop,
  output ac3hp_pkg::ac3hp_desc_t  head,
  output ac3hp_pkg::ac3hp_qstat_t qstat
);
  import ac3hp_pkg::*;

  ac3hp_desc_t ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign head = ent[rptr];
  assign qstat.full = (count == 2'd2);
  assign qstat.not_empty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= push_desc;
  end
endmodule
`default_nettype wire

### sv/ac3hp_back.sv
`default_nettype none
module ac3hp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ac3hp_pkg::ac3hp_qstat_t     qstat,
  input  ac3hp_pkg::ac3hp_desc_t      head,
  output logic                        pop,
  output logic [ac3hp_pkg::RamAw-1:0] rd_addr_a,
  output logic [ac3hp_pkg::RamAw-1:0] rd_addr_b,
  input  logic [7:0]                  rd_data_a,
  input  logic [7:0]                  rd_data_b,
  ac3hp_out_if.source                 out_ch
);
  import ac3hp_pkg::*;

  localparam logic [4:0] W_IDLE  = 5'd0;
  localparam logic [4:0] W_STRM  = 5'd1;
  localparam logic [4:0] W_FSCOD = 5'd2;
  localparam logic [4:0] W_NBC   = 5'd3;
  localparam logic [4:0] W_AL    = 5'd4;
  localparam logic [4:0] W_F1    = 5'd5;
  localparam logic [4:0] W_A0S   = 5'd6;
  localparam logic [4:0] W_A0F   = 5'd7;
  localparam logic [4:0] W_ST1   = 5'd8;
  localparam logic [4:0] W_MIX   = 5'd9;
  localparam logic [4:0] W_LFE   = 5'd10;
  localparam logic [4:0] W_S0    = 5'd11;
  localparam logic [4:0] W_A0B   = 5'd12;
  localparam logic [4:0] W_S2    = 5'd13;
  localparam logic [4:0] W_MD    = 5'd14;
  localparam logic [4:0] W_MD3   = 5'd15;
  localparam logic [4:0] W_AC2   = 5'd16;
  localparam logic [4:0] W_AC2B  = 5'd17;
  localparam logic [4:0] W_BLK   = 5'd18;
  localparam logic [4:0] W_BLKF  = 5'd19;
  localparam logic [4:0] W_INFO  = 5'd20;
  localparam logic [4:0] W_BSM   = 5'd21;
  localparam logic [4:0] W_FIN   = 5'd22;

  logic [4:0] state, state_next;
  logic       phase, phase_next;
  logic [9:0] pos, pos_next;
  logic [1:0] strmtyp, strmtyp_next;
  logic [1:0] nbc, nbc_next;
  logic [2:0] acm, acm_next;
  logic       lfeon, lfeon_next;
  logic [2:0] blk, blk_next;
  logic [2:0] bsm, bsm_next;

  logic        k_valid, k_eac3, k_sur;
  logic [4:0]  k_bsid;
  logic [2:0]  k_bsmod, k_acmod;
  logic [15:0] k_rate;

  // Header decode of the frame at the queue head.
  logic        dec_acc, dec_eac3, dec_sur;
  logic [4:0]  dec_bsid;
  logic [1:0]  dec_fscod, dec_fscod2;
  logic [2:0]  dec_acmod;
  logic [15:0] dec_rate;

  assign dec_acc = (head.count >= MIN_LEN) && (head.hdr[0] == SYNC_HI) &&
                   (head.hdr[1] == SYNC_LO);
  assign dec_bsid   = head.hdr[5][7:3];
  assign dec_eac3   = dec_bsid > BSID_AC3_MAX;
  assign dec_fscod  = head.hdr[4][7:6];
  assign dec_fscod2 = (dec_eac3 && dec_fscod == FSCOD_EXT) ? head.hdr[4][5:4] : 2'd3;
  assign dec_rate   = rate_hz(dec_fscod, dec_fscod2);
  assign dec_acmod  = dec_eac3 ? head.hdr[4][3:1] : head.hdr[6][7:5];
  assign dec_sur    = !dec_eac3 && (dec_acmod == ACMOD_STEREO) &&
                      (head.hdr[6][4:3] == DSUR_ON);

  // Bit window at pos; bits past the frame or past the buffer read as zero.
  logic [10:0] total;
  logic [15:0] shifted;
  logic [4:0]  win;
  logic [10:0] pbit;

  assign total     = {1'b0, head.count, 3'b000};
  assign rd_addr_a = {head.bank, pos[IdxW+2:3]};
  assign rd_addr_b = {head.bank, pos[IdxW+2:3] + IdxW'(1)};
  assign shifted   = {rd_data_a, rd_data_b} << pos[2:0];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      pbit = {1'b0, pos} + 11'(i);
      win[4-i] = shifted[15-i] && (pbit < total) && (pbit < 11'(BankBytes * 8));
    end
  end

  logic       out_free;
  logic       fin;
  logic [2:0] fin_bsmod;
  logic       commit;
  logic [2:0] nblk_m1;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign nblk_m1 = (nbc == 2'd1) ? 3'd1 : (nbc == 2'd2) ? 3'd2 : 3'd5;

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    pos_next     = pos;
    strmtyp_next = strmtyp;
    nbc_next     = nbc;
    acm_next     = acm;
    lfeon_next   = lfeon;
    blk_next     = blk;
    bsm_next     = bsm;
    fin          = 1'b0;
    case (state)
      W_IDLE: begin
        if (qstat.not_empty) begin
          if (dec_acc && dec_eac3) begin
            state_next = W_STRM;
            pos_next   = 10'd16;
            phase_next = 1'b0;
          end else if (out_free) begin
            fin = 1'b1;
          end
        end
      end
      W_FIN: begin
        if (out_free) begin
          fin = 1'b1;
          state_next = W_IDLE;
        end
      end
      default: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          case (state)
            W_STRM: begin
              strmtyp_next = win[4:3];
              pos_next = pos + 10'd16;
              state_next = W_FSCOD;
            end
            W_FSCOD: begin
              if (win[4:3] == FSCOD_EXT) begin
                nbc_next = 2'd3;
                pos_next = pos + 10'd4;
                state_next = W_AL;
              end else begin
                pos_next = pos + 10'd2;
                state_next = W_NBC;
              end
            end
            W_NBC: begin
              nbc_next = win[4:3];
              pos_next = pos + 10'd2;
              state_next = W_AL;
            end
            W_AL: begin
              acm_next = win[4:2];
              lfeon_next = win[1];
              pos_next = pos + 10'd14;
              state_next = W_F1;
            end
            W_F1: begin
              pos_next = pos + (win[4] ? 10'd9 : 10'd1);
              state_next = W_A0S;
            end
            W_A0S: begin
              if (acm == ACMOD_DUAL) pos_next = pos + 10'd5;
              state_next = W_A0F;
            end
            W_A0F: begin
              if (acm == ACMOD_DUAL) pos_next = pos + (win[4] ? 10'd9 : 10'd1);
              state_next = W_ST1;
            end
            W_ST1: begin
              if (strmtyp == 2'd1) pos_next = pos + (win[4] ? 10'd17 : 10'd1);
              state_next = W_MIX;
            end
            W_MIX: begin
              if (win[4]) begin
                pos_next = pos + 10'd1 + ((acm > ACMOD_STEREO) ? 10'd2 : 10'd0) +
                           ((acm[0] && acm > ACMOD_STEREO) ? 10'd6 : 10'd0) +
                           (acm[2] ? 10'd6 : 10'd0);
                state_next = W_LFE;
              end else begin
                pos_next = pos + 10'd1;
                state_next = W_INFO;
              end
            end
            W_LFE: begin
              if (lfeon) pos_next = pos + (win[4] ? 10'd6 : 10'd1);
              state_next = (strmtyp == 2'd0) ? W_S0 : W_INFO;
            end
            W_S0: begin
              pos_next = pos + (win[4] ? 10'd7 : 10'd1);
              state_next = W_A0B;
            end
            W_A0B: begin
              if (acm == ACMOD_DUAL) pos_next = pos + (win[4] ? 10'd7 : 10'd1);
              state_next = W_S2;
            end
            W_S2: begin
              pos_next = pos + (win[4] ? 10'd7 : 10'd1);
              state_next = W_MD;
            end
            W_MD: begin
              state_next = W_AC2;
              case (win[4:3])
                2'd1: pos_next = pos + 10'd7;
                2'd2: pos_next = pos + 10'd14;
                2'd3: begin
                  pos_next = pos + 10'd2;
                  state_next = W_MD3;
                end
                default: pos_next = pos + 10'd2;
              endcase
            end
            W_MD3: begin
              pos_next = pos + 10'd5 + ((10'(win) + 10'd2) << 3);
              state_next = W_AC2;
            end
            W_AC2: begin
              if (acm < ACMOD_STEREO) pos_next = pos + (win[4] ? 10'd15 : 10'd1);
              state_next = W_AC2B;
            end
            W_AC2B: begin
              if (acm == ACMOD_DUAL) pos_next = pos + (win[4] ? 10'd15 : 10'd1);
              state_next = W_BLK;
            end
            W_BLK: begin
              if (win[4] && nbc == 2'd0) begin
                pos_next = pos + 10'd6;
                state_next = W_INFO;
              end else if (win[4]) begin
                pos_next = pos + 10'd1;
                blk_next = 3'd0;
                state_next = W_BLKF;
              end else begin
                pos_next = pos + 10'd1;
                state_next = W_INFO;
              end
            end
            W_BLKF: begin
              pos_next = pos + (win[4] ? 10'd6 : 10'd1);
              blk_next = blk + 3'd1;
              if (blk == nblk_m1) state_next = W_INFO;
            end
            W_INFO: begin
              pos_next = pos + 10'd1;
              if (win[4]) begin
                state_next = W_BSM;
              end else begin
                bsm_next = 3'd0;
                state_next = W_FIN;
              end
            end
            W_BSM: begin
              bsm_next = (({1'b0, pos} + 11'd3) > total) ? 3'd0 : win[4:2];
              state_next = W_FIN;
            end
            default: state_next = W_IDLE;
          endcase
        end
      end
    endcase
  end

  assign pop = fin;
  assign fin_bsmod = (state == W_FIN) ? bsm : head.hdr[5][2:0];
  assign commit = fin && dec_acc &&
                  (!k_valid || k_eac3 != dec_eac3 || k_sur != dec_sur ||
                   k_bsid != dec_bsid || k_bsmod != fin_bsmod || k_acmod != dec_acmod ||
                   k_rate != dec_rate);

  logic        n_eac3, n_sur;
  logic [2:0]  n_bsmod, n_acmod;

  assign n_eac3  = commit ? dec_eac3 : k_eac3;
  assign n_sur   = commit ? dec_sur : k_sur;
  assign n_bsmod = commit ? fin_bsmod : k_bsmod;
  assign n_acmod = commit ? dec_acmod : k_acmod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= W_IDLE;
      phase   <= 1'b0;
      k_valid <= 1'b0;
      k_eac3  <= 1'b0;
      k_sur   <= 1'b0;
      k_bsid  <= '0;
      k_bsmod <= '0;
      k_acmod <= '0;
      k_rate  <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (commit) begin
        k_valid <= 1'b1;
        k_eac3  <= dec_eac3;
        k_sur   <= dec_sur;
        k_bsid  <= dec_bsid;
        k_bsmod <= fin_bsmod;
        k_acmod <= dec_acmod;
        k_rate  <= dec_rate;
      end
      if (fin) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    strmtyp <= strmtyp_next;
    nbc     <= nbc_next;
    acm     <= acm_next;
    lfeon   <= lfeon_next;
    blk     <= blk_next;
    bsm     <= bsm_next;
    if (fin) begin
      out_ch.accepted         <= dec_acc;
      out_ch.changed          <= commit;
      out_ch.is_eac3          <= n_eac3;
      out_ch.bitstream_id     <= commit ? dec_bsid : k_bsid;
      out_ch.service_mode     <= n_bsmod;
      out_ch.coding_mode      <= n_acmod;
      out_ch.dolby_surround   <= n_sur;
      out_ch.sample_rate_hz   <= commit ? dec_rate : k_rate;
      out_ch.dvb_audio_type   <= comp_type(n_eac3, n_bsmod, n_acmod, n_sur);
      out_ch.attributes_valid <= k_valid || commit;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.not_empty) else $error("pop from an empty queue");
  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    fin |-> (!out_ch.valid || out_ch.ready)) else $error("result overwrote a waiting one");
  a_walk_head: assert property (@(posedge clk) disable iff (rst)
    (state != W_IDLE) |-> qstat.not_empty) else $error("walk without a queued frame");
  a_commit_acc: assert property (@(posedge clk) disable iff (rst)
    commit |=> k_valid) else $error("commit did not set the valid flag");
endmodule
`default_nettype wire
